@@ hdl/rmbd_pkg.sv @@
// ----------------------------------------------------------------------------
// rmbd_pkg
// Shared types and constants of the RGBA mipmap 2x2 box downsampler.
// ----------------------------------------------------------------------------
package rmbd_pkg;

  // Default limits on the source frame size
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  // Field widths
  localparam int PIX_W   = 32;
  localparam int LANES   = 4;
  localparam int LANE_W  = 8;
  localparam int PAIR_W  = LANE_W + 1;       // sum of two lanes
  localparam int SUMS_W  = LANES * PAIR_W;   // one line buffer word
  localparam int DIM_W   = 12;               // size registers and counters
  localparam int INDEX_W = 2;

  // Register indexes
  localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Per-word control decoded from the frame position
  typedef struct packed {
    logic err;        // frame size is invalid
    logic frame_end;  // last word of the frame
    logic hold;       // even column, keep the word for its pair
    logic wr;         // even row, store pair sums
    logic emit;       // this word gives a result
    logic w_one;      // width is 1, replicate horizontally
    logic h_one;      // height is 1, replicate vertically
  } ctrl_t;

endpackage

@@ hdl/rmbd_line_buf.sv @@
// ----------------------------------------------------------------------------
// rmbd_line_buf
// Line buffer of pair sums with registered read and write-to-read bypass.
// ----------------------------------------------------------------------------
module rmbd_line_buf #(
  parameter int DEPTH = rmbd_pkg::MAX_WIDTH_DEF / 2,
  parameter int IDX_W = 10
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [rmbd_pkg::SUMS_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [rmbd_pkg::SUMS_W-1:0] rd_data
);

  logic [rmbd_pkg::SUMS_W-1:0] mem [DEPTH];
  logic [rmbd_pkg::SUMS_W-1:0] mem_q;
  logic [rmbd_pkg::SUMS_W-1:0] byp_data;
  logic                        byp;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a write at the same edge to the same entry is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      byp      <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : mem_q;

endmodule

@@ hdl/rmbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rmbd_ctrl
// Size registers, frame position counters and per-word control decode.
// ----------------------------------------------------------------------------
module rmbd_ctrl #(
  parameter int MAX_WIDTH  = rmbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rmbd_pkg::MAX_HEIGHT_DEF,
  parameter int IDX_W      = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         cfg_we,
  input  logic [rmbd_pkg::INDEX_W-1:0] cfg_index,
  input  logic [rmbd_pkg::DIM_W-1:0]   cfg_data,
  output rmbd_pkg::ctrl_t              ctl,
  output logic [IDX_W-1:0]             line_idx
);

  localparam int DW = rmbd_pkg::DIM_W;

  logic [DW-1:0] image_width;
  logic [DW-1:0] image_height;
  logic [DW-1:0] column_count;
  logic [DW-1:0] row_count;
  logic [DW-1:0] column_count_next;
  logic [DW-1:0] row_count_next;
  logic [DW-1:0] w;
  logic [DW-1:0] h;
  logic [DW-1:0] half_col;
  logic          w_pow2;
  logic          h_pow2;
  logic          size_ok;
  logic          col_end;
  logic          row_end;
  logic          pair_done;
  logic          cfg_hit;

  // Zero dimension frames as if it were 1
  assign w = (image_width  == '0) ? DW'(1) : image_width;
  assign h = (image_height == '0) ? DW'(1) : image_height;

  assign w_pow2 = (image_width  != '0) && ((image_width  & (image_width  - DW'(1))) == '0);
  assign h_pow2 = (image_height != '0) && ((image_height & (image_height - DW'(1))) == '0);

  assign size_ok = w_pow2 && h_pow2
                && (32'(image_width)  <= 32'(MAX_WIDTH))
                && (32'(image_height) <= 32'(MAX_HEIGHT))
                && !((image_width == DW'(1)) && (image_height == DW'(1)));

  assign col_end = (column_count == w - DW'(1));
  assign row_end = (row_count    == h - DW'(1));

  // Decode for the word at the current position
  always_comb begin
    pair_done     = (w == DW'(1)) || column_count[0];
    ctl.err       = !size_ok;
    ctl.frame_end = col_end && row_end;
    ctl.w_one     = (w == DW'(1));
    ctl.h_one     = (h == DW'(1));
    ctl.hold      = size_ok && !pair_done;
    ctl.wr        = size_ok && pair_done && (h != DW'(1)) && !row_count[0];
    ctl.emit      = size_ok ? (pair_done && !ctl.wr) : (col_end && row_end);
  end

  assign half_col = column_count >> 1;
  assign line_idx = half_col[IDX_W-1:0];

  assign cfg_hit = cfg_we && ((cfg_index == rmbd_pkg::REG_IMAGE_WIDTH) ||
                              (cfg_index == rmbd_pkg::REG_IMAGE_HEIGHT));

  // Position counters; a size write restarts the frame
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (cfg_hit) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (accept) begin
      if (col_end) begin
        column_count_next = '0;
        row_count_next    = row_end ? '0 : row_count + DW'(1);
      end else begin
        column_count_next = column_count + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DW'(2);
      image_height <= DW'(2);
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (cfg_we) begin
        case (cfg_index)
          rmbd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          rmbd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ hdl/rgba_mipmap_box_downsample_core.sv @@
// ----------------------------------------------------------------------------
// rgba_mipmap_box_downsample_core
// Next mipmap level of a raster frame of packed RGBA words, 2x2 box filter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / pixel_in) takes one source word per
//   cycle in raster order while in_stall is low. Output channel (out_valid /
//   out_stall / pixel_out, last, error) gives one averaged word per 2x2
//   block, on the block's bottom-right word; last marks the final result of
//   the frame. A frame of invalid size gives only one result, on its last
//   word: pixel_out 0, last and error set.
//   Size registers are written through cfg_we / cfg_index / cfg_data while
//   the block is idle; a size write restarts the frame at its first word.
//   Throughput is one word per cycle while the receiver does not stall, set
//   by the single-port-write line buffer with one read and one write per
//   cycle. A word passes through an input stage that also reads the line
//   buffer, then the output register.
//   When the receiver stalls, the output register holds its word and the
//   input stage keeps the next one; in_stall rises only when both are full.
//   Reset sets the size to 2x2, restarts the frame and empties both stages;
//   the line buffer needs no clearing, an odd row reads only what the row
//   above it wrote.
// ----------------------------------------------------------------------------
module rgba_mipmap_box_downsample_core #(
  parameter int MAX_WIDTH  = rmbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rmbd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rmbd_pkg::PIX_W-1:0]   pixel_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rmbd_pkg::PIX_W-1:0]   pixel_out,
  output logic                         last,
  output logic                         error,
  input  logic                         cfg_we,
  input  logic [rmbd_pkg::INDEX_W-1:0] cfg_index,
  input  logic [rmbd_pkg::DIM_W-1:0]   cfg_data
);

  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int LW         = rmbd_pkg::LANE_W;
  localparam int PW         = rmbd_pkg::PAIR_W;

  rmbd_pkg::ctrl_t             ctl;
  rmbd_pkg::ctrl_t             s1_ctl;
  logic [IDX_W-1:0]            line_idx;
  logic [IDX_W-1:0]            s1_idx;
  logic                        s1_valid;
  logic [rmbd_pkg::PIX_W-1:0]  s1_pixel;
  logic [rmbd_pkg::PIX_W-1:0]  held_pixel;
  logic                        accept;
  logic                        s1_adv;
  logic [rmbd_pkg::SUMS_W-1:0] hs;
  logic [rmbd_pkg::SUMS_W-1:0] up;
  logic [rmbd_pkg::SUMS_W-1:0] line_rd;
  logic [rmbd_pkg::PIX_W-1:0]  avg;
  logic [LW-1:0]               a_lane;
  logic [LW-1:0]               b_lane;
  logic [PW:0]                 quad;

  // Handshake: input stage moves when the output register is free or taken
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  rmbd_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .line_idx  (line_idx)
  );

  rmbd_line_buf #(
    .DEPTH (LINE_DEPTH),
    .IDX_W (IDX_W)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (s1_adv && s1_ctl.wr),
    .wr_addr (s1_idx),
    .wr_data (hs),
    .rd_en   (accept),
    .rd_addr (line_idx),
    .rd_data (line_rd)
  );

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel_in;
      s1_ctl   <= ctl;
      s1_idx   <= line_idx;
    end
  end

  // Even-column word waits for its odd partner
  always_ff @(posedge clk) begin
    if (rst) begin
      held_pixel <= '0;
    end else if (s1_adv && s1_ctl.hold) begin
      held_pixel <= s1_pixel;
    end
  end

  // Horizontal pair sums, then vertical sum and truncating divide by four
  assign up = s1_ctl.h_one ? hs : line_rd;

  always_comb begin
    hs  = '0;
    avg = '0;
    for (int k = 0; k < rmbd_pkg::LANES; k++) begin
      a_lane = s1_pixel[k*LW +: LW];
      b_lane = s1_ctl.w_one ? a_lane : held_pixel[k*LW +: LW];
      hs[k*PW +: PW] = PW'(a_lane) + PW'(b_lane);
    end
    for (int k = 0; k < rmbd_pkg::LANES; k++) begin
      quad = (PW+1)'(hs[k*PW +: PW]) + (PW+1)'(up[k*PW +: PW]);
      avg[k*LW +: LW] = quad[PW:2];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_ctl.emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pixel_out <= s1_ctl.err ? '0 : avg;
      last      <= s1_ctl.frame_end;
      error     <= s1_ctl.err;
    end
  end

endmodule

@@ tb/tb_rgba_mipmap_box_downsample_core.sv @@
// ----------------------------------------------------------------------------
// tb_rgba_mipmap_box_downsample_core
// Self-checking bench for the 2x2 box mipmap downsampler. A scoreboard class
// predicts every averaged word, including the width-1 and height-1
// replication and the error word of bad frame sizes. The input and output
// sides idle and stall at random, one long receiver hold fills the block,
// and size writes restart the frame between phases.
// ----------------------------------------------------------------------------
module tb_rgba_mipmap_box_downsample_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W          = rmbd_pkg::PIX_W;
  localparam int DIM_W          = rmbd_pkg::DIM_W;
  localparam int SUMS_W         = rmbd_pkg::SUMS_W;
  localparam int INDEX_W        = rmbd_pkg::INDEX_W;
  localparam int LANES          = rmbd_pkg::LANES;
  localparam int LANE_W         = rmbd_pkg::LANE_W;
  localparam int PAIR_W         = rmbd_pkg::PAIR_W;
  localparam int MAX_WIDTH_DEF  = rmbd_pkg::MAX_WIDTH_DEF;
  localparam int MAX_HEIGHT_DEF = rmbd_pkg::MAX_HEIGHT_DEF;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = 4;      // block latency plus margin
  localparam int RANDOM_WORDS  = 195;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
    logic             err;
  } texel_t;

  // Predicts the downsampled words and checks them in order
  class mipmap_scoreboard;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    int unsigned       col;
    int unsigned       row;
    logic [PIX_W-1:0]  held;
    logic [SUMS_W-1:0] line_sums [MAX_WIDTH_DEF/2];
    texel_t            pending_texels [$];
    int                mismatches;

    function new();
      width      = DIM_W'(2);
      height     = DIM_W'(2);
      col        = 0;
      row        = 0;
      held       = '0;
      mismatches = 0;
    endfunction

    // A size write also restarts the frame
    function void write_size(logic [INDEX_W-1:0] index, logic [DIM_W-1:0] value);
      if (index == rmbd_pkg::REG_IMAGE_WIDTH) begin
        width = value;
      end else if (index == rmbd_pkg::REG_IMAGE_HEIGHT) begin
        height = value;
      end else begin
        return;
      end
      col = 0;
      row = 0;
    endfunction

    function bit size_ok();
      if (width == 0 || (width & (width - 1)) != 0) return 0;
      if (height == 0 || (height & (height - 1)) != 0) return 0;
      if (width > MAX_WIDTH_DEF || height > MAX_HEIGHT_DEF) return 0;
      return !(width == 1 && height == 1);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned       w;
      int unsigned       h;
      int unsigned       idx;
      int unsigned       a;
      int unsigned       b;
      int unsigned       s;
      bit                frame_end;
      logic [SUMS_W-1:0] hs;
      logic [SUMS_W-1:0] up;
      texel_t            t;
      w = (width == 0) ? 1 : width;
      h = (height == 0) ? 1 : height;
      frame_end = (col + 1 >= w) && (row + 1 >= h);
      if (!size_ok()) begin
        // bad size: only one error word, on the frame's last word
        if (frame_end) begin
          t.pix  = '0;
          t.last = 1'b1;
          t.err  = 1'b1;
          pending_texels.push_back(t);
        end
      end else if (w != 1 && col % 2 == 0) begin
        held = px;
      end else begin
        idx = col >> 1;
        for (int k = 0; k < LANES; k++) begin
          a = 32'(px[LANE_W*k +: LANE_W]);
          b = (w == 1) ? a : 32'(held[LANE_W*k +: LANE_W]);
          hs[PAIR_W*k +: PAIR_W] = PAIR_W'(a + b);
        end
        if (h != 1 && row % 2 == 0) begin
          line_sums[idx] = hs;
        end else begin
          up = (h == 1) ? hs : line_sums[idx];
          for (int k = 0; k < LANES; k++) begin
            s = 32'(hs[PAIR_W*k +: PAIR_W]) + 32'(up[PAIR_W*k +: PAIR_W]);
            t.pix[LANE_W*k +: LANE_W] = LANE_W'(s >> 2);
          end
          t.last = frame_end;
          t.err  = 1'b0;
          pending_texels.push_back(t);
        end
      end
      // raster position
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function void check_texel(logic [PIX_W-1:0] px, logic lst, logic err);
      texel_t t;
      if (pending_texels.size() == 0) begin
        $error("unexpected word: pixel_out %h last %b error %b", px, lst, err);
        mismatches++;
        return;
      end
      t = pending_texels.pop_front();
      if (px !== t.pix) begin
        $error("pixel_out: expected %h actual %h", t.pix, px);
        mismatches++;
      end
      if (lst !== t.last) begin
        $error("last: expected %b actual %b", t.last, lst);
        mismatches++;
      end
      if (err !== t.err) begin
        $error("error: expected %b actual %b", t.err, err);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   pixel_in  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PIX_W-1:0]   pixel_out;
  logic               last;
  logic               error;
  logic               cfg_we    = 1'b0;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]   cfg_data  = '0;

  mipmap_scoreboard sb = new();
  idle_mode_t       traffic_mode = IDLE_NONE;
  int               hold_burst = 0;
  int               cycles = 0;

  rgba_mipmap_box_downsample_core u_top (.*);

  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_texel(pixel_out, last, error);
  end

  function automatic int idle_pct(idle_mode_t m, bit receiver);
    if (m == IDLE_BOTH) return 10;
    if (m == (receiver ? IDLE_RECEIVER : IDLE_SENDER)) return 67;
    return 0;
  endfunction

  // Receiver: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_burst > 0) begin
      out_stall <= 1'b1;
      hold_burst--;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct(traffic_mode, 1'b1));
    end
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    case ($urandom_range(9))
      0: p = '0;
      1: p = '1;
      2: begin
        for (int k = 0; k < LANES; k++)
          p[LANE_W*k +: LANE_W] = {LANE_W{1'($urandom_range(1))}};
      end
      default: p = $urandom;
    endcase
    return p;
  endfunction

  // All driver tasks start and end at a falling edge with nothing assigned yet
  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_size(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    write_reg(rmbd_pkg::REG_IMAGE_WIDTH, w);
    write_reg(rmbd_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  task automatic send_word(logic [PIX_W-1:0] px);
    while ($urandom_range(99) < idle_pct(traffic_mode, 1'b0)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected word, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_texels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random_words(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, int n);
    set_size(w, h);
    repeat (n) send_word(rand_pixel());
    drain();
  endtask

  localparam logic [PIX_W-1:0] SQUARE_WORDS [12] = '{
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'hFF00_0001, 32'h01FF_0000, 32'h0000_FF01, 32'h0001_0203
  };

  initial begin
    int          random_sent;
    int          phase;
    int unsigned w;
    int unsigned h;
    int unsigned frame_len;
    int          n;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset size 2x2, all-ones, all-zeros and truncation
    foreach (SQUARE_WORDS[i]) send_word(SQUARE_WORDS[i]);
    drain();
    // width 1 replicates horizontally
    set_size(12'd1, 12'd2);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0001);
    drain();
    // height 1 replicates vertically
    set_size(12'd2, 12'd1);
    send_word(32'h80FF_0001);
    send_word(32'h7F00_0102);
    drain();
    // 1x1, non-power-of-two and zero sizes give one error word
    set_size(12'd1, 12'd1);
    send_word(32'hFFFF_FFFF);
    drain();
    set_size(12'd3, 12'd1);
    repeat (3) send_word(rand_pixel());
    drain();
    set_size(12'd0, 12'd0);
    send_word(32'h1234_5678);
    drain();

    // Wide, tall, bad and largest sizes
    traffic_mode = IDLE_BOTH;
    run_random_words(12'd64, 12'd2, 128);
    traffic_mode = IDLE_NONE;
    run_random_words(12'd1, 12'd64, 64);
    traffic_mode = IDLE_RECEIVER;
    run_random_words(12'd64, 12'd1, 64);
    traffic_mode = IDLE_NONE;
    run_random_words(12'd12, 12'd0, 12);
    traffic_mode = IDLE_SENDER;
    run_random_words(12'd0, 12'd6, 6);
    traffic_mode = IDLE_NONE;
    run_random_words(12'd2048, 12'd2048, 32);

    // Long receiver hold with the sender running flat out
    traffic_mode = IDLE_NONE;
    set_size(12'd16, 12'd8);
    hold_burst = 100;
    repeat (128) send_word(rand_pixel());
    drain();

    // Random frames, mostly valid small sizes, some bad sizes and cut frames
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_WORDS) begin
      traffic_mode = idle_mode_t'(phase % 4);
      if ($urandom_range(9) < 8) begin
        w = 1 << $urandom_range(0, 4);
        h = 1 << $urandom_range(0, 3);
        if (w == 1 && h == 1) w = 2;
      end else begin
        w = $urandom_range(0, 24);
        h = $urandom_range(0, 6);
      end
      if ($urandom_range(3) == 0) begin
        write_reg(rmbd_pkg::REG_IMAGE_WIDTH, DIM_W'(w));
        w = sb.width;
        h = sb.height;
      end else begin
        set_size(DIM_W'(w), DIM_W'(h));
      end
      frame_len = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      if ($urandom_range(4) == 0) n = $urandom_range(1, frame_len);
      else n = frame_len * $urandom_range(1, 2);
      if (n > RANDOM_WORDS - random_sent) n = RANDOM_WORDS - random_sent;
      repeat (n) send_word(rand_pixel());
      drain();
      random_sent += n;
      phase++;
    end

    traffic_mode = IDLE_NONE;
    repeat (8) @(negedge clk);
    if (sb.pending_texels.size() != 0)
      $error("%0d expected words never arrived", sb.pending_texels.size());
    if (sb.mismatches == 0 && sb.pending_texels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
